### src/event_table_dedup_insert_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef EVENT_TABLE_DEDUP_INSERT_UNIT_MACROS_SVH
`define EVENT_TABLE_DEDUP_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ETD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ETD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/etd_pkg.sv
`default_nettype none

package etd_pkg;

    // Table geometry
    localparam int EVENT_SLOTS = 32;
    localparam int IDX_W       = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);

    // Field widths fixed by the stream format
    localparam int ADDR_W  = 16;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 8;
    localparam int TEMP_W  = 16;
    localparam int COUNT_W = 6;
    localparam int SLOT_W  = 5;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 16;

    localparam logic [ADDR_W-1:0] MARKER_RESET = 16'hFFFF;

    // Register map: word index taken from paddr[2]
    localparam logic REG_EMPTY_MARKER = 1'b0;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [TEMP_W-1:0]  temp_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLOT_W-1:0]  slot_t;

    typedef enum logic [1:0] {
        STAT_STORED = 2'd0,
        STAT_DUP    = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_NOSLOT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_SCAN   = 2'd1,
        FSM_FINISH = 2'd2
    } fsm_t;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic dup;
        logic have_empty;
        idx_t empty_idx;
        cnt_t scanned;
    } probe_t;

    // Slot write broadcast to all cells
    typedef struct packed {
        logic  en;
        idx_t  idx;
        addr_t addr;
        time_t tstamp;
        kind_t kind;
        temp_t temp;
    } slot_wr_t;

endpackage

`default_nettype wire

### src/etd_cell.sv
`default_nettype none

module etd_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire etd_pkg::idx_t    cell_idx,
    input  wire etd_pkg::addr_t   empty_marker,
    input  wire etd_pkg::cnt_t    stored_count,
    input  wire etd_pkg::addr_t   key_addr,
    input  wire etd_pkg::time_t   key_time,
    input  wire etd_pkg::kind_t   key_kind,
    input  wire etd_pkg::slot_wr_t wr,
    input  wire etd_pkg::probe_t  probe_in,
    output etd_pkg::probe_t       probe_out
);

    etd_pkg::addr_t  addr_reg;
    etd_pkg::time_t  time_reg;
    etd_pkg::kind_t  kind_reg;
    etd_pkg::temp_t  temp_reg;
    etd_pkg::probe_t probe_reg;
    etd_pkg::probe_t probe_next;
    logic            live;

    // Hold one slot; load it when the write targets this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= etd_pkg::MARKER_RESET;
            time_reg <= '0;
            kind_reg <= '0;
            temp_reg <= '0;
        end
        else if (wr.en && (wr.idx == cell_idx))
        begin
            addr_reg <= wr.addr;
            time_reg <= wr.tstamp;
            kind_reg <= wr.kind;
            temp_reg <= wr.temp;
        end
    end

    // Judge this slot against the passing token
    always_comb
    begin
        live       = !probe_in.dup && (probe_in.scanned <= stored_count);
        probe_next = probe_in;
        if (live)
        begin
            if (addr_reg == key_addr)
            begin
                probe_next.scanned = probe_in.scanned + etd_pkg::cnt_t'(1);
                if ((time_reg == key_time) && (kind_reg == key_kind))
                begin
                    probe_next.dup = 1'b1;
                end
            end
            else if (addr_reg == empty_marker)
            begin
                if (!probe_in.have_empty)
                begin
                    probe_next.have_empty = 1'b1;
                    probe_next.empty_idx  = cell_idx;
                    probe_next.scanned    = probe_in.scanned + etd_pkg::cnt_t'(1);
                end
            end
            else
            begin
                probe_next.scanned = probe_in.scanned + etd_pkg::cnt_t'(1);
            end
        end
    end

    // Advance the token; payload holds once the token has passed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else if (probe_in.valid)
        begin
            probe_reg <= probe_next;
        end
        else
        begin
            probe_reg.valid <= 1'b0;
        end
    end

    assign probe_out = probe_reg;

endmodule

`default_nettype wire

### src/event_table_dedup_insert_unit.sv
// Channel   | Dir | Beat                                  | Handshake
// s_axis    | in  | one node event                        | s_tvalid / s_tready
// m_axis    | out | insert result, one per event          | m_tvalid / m_tready
// apb       | in  | empty marker register at byte addr 0  | psel/penable, pready high
//
// An event is taken in idle; its result beat follows once the scan token, launched
// from start_reg, has walked the row through every cell register, been seen to leave
// it, and been committed. One event is in flight at a time; the next is taken in the
// cycle after the commit.
// Reset clears the row to the reset marker and the count to zero at once.
// A result stalled on m_tready holds back the next commit, not the next acceptance.
`default_nettype none

module event_table_dedup_insert_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: node_addr[15:0], event_time[47:16], event_kind[55:48],
    //          temperature[71:56]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,
    // m_tdata: status[1:0], event_count[7:2], slot[12:8], zero[15:13]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    etd_pkg::fsm_t     state_reg;
    etd_pkg::fsm_t     state_next;
    etd_pkg::addr_t    marker_reg;
    etd_pkg::cnt_t     count_reg;
    etd_pkg::cnt_t     count_next;
    etd_pkg::addr_t    key_addr_reg;
    etd_pkg::time_t    key_time_reg;
    etd_pkg::kind_t    key_kind_reg;
    etd_pkg::temp_t    key_temp_reg;
    logic              start_reg;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic              in_fire;
    logic              out_free;
    logic              commit;
    logic              table_full;
    etd_pkg::status_t  status;
    etd_pkg::probe_t   chain [0:etd_pkg::EVENT_SLOTS];
    etd_pkg::probe_t   result;
    etd_pkg::slot_wr_t wr;
    etd_pkg::slot_t    slot_out;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= etd_pkg::MARKER_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == etd_pkg::REG_EMPTY_MARKER))
        begin
            marker_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == etd_pkg::REG_EMPTY_MARKER)
        begin
            prdata = 32'(marker_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            etd_pkg::FSM_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = etd_pkg::FSM_SCAN;
                end
            end
            etd_pkg::FSM_SCAN:
            begin
                if (result.valid)
                begin
                    state_next = etd_pkg::FSM_FINISH;
                end
            end
            etd_pkg::FSM_FINISH:
            begin
                if (out_free)
                begin
                    state_next = etd_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = etd_pkg::FSM_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            etd_pkg::FSM_IDLE:   s_tready = 1'b1;
            etd_pkg::FSM_SCAN:   s_tready = 1'b0;
            etd_pkg::FSM_FINISH: commit   = out_free;
            default:             s_tready = 1'b0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= etd_pkg::FSM_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_fire;
        end
    end

    // Latch the event key on acceptance
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_addr_reg <= s_tdata[15:0];
            key_time_reg <= s_tdata[47:16];
            key_kind_reg <= s_tdata[55:48];
            key_temp_reg <= s_tdata[71:56];
        end
    end

    // Launch the scan token into the first cell
    assign chain[0] = etd_pkg::probe_t'({start_reg,
                                         {($bits(etd_pkg::probe_t) - 1){1'b0}}});

    // Row of slot cells
    for (genvar g = 0; g < etd_pkg::EVENT_SLOTS; g++)
    begin : g_cell
        etd_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cell_idx     (etd_pkg::idx_t'(g)),
            .empty_marker (marker_reg),
            .stored_count (count_reg),
            .key_addr     (key_addr_reg),
            .key_time     (key_time_reg),
            .key_kind     (key_kind_reg),
            .wr           (wr),
            .probe_in     (chain[g]),
            .probe_out    (chain[g+1])
        );
    end

    assign result = chain[etd_pkg::EVENT_SLOTS];

    // Decide the outcome once the token leaves the row
    assign table_full = (count_reg >= etd_pkg::cnt_t'(etd_pkg::EVENT_SLOTS));

    always_comb
    begin
        priority if (table_full)
        begin
            status = etd_pkg::STAT_FULL;
        end
        else if (result.dup)
        begin
            status = etd_pkg::STAT_DUP;
        end
        else if (!result.have_empty)
        begin
            status = etd_pkg::STAT_NOSLOT;
        end
        else
        begin
            status = etd_pkg::STAT_STORED;
        end
    end

    // Write the event into its slot and bump the count
    always_comb
    begin
        wr.en      = commit && (status == etd_pkg::STAT_STORED);
        wr.idx     = result.empty_idx;
        wr.addr    = key_addr_reg;
        wr.tstamp  = key_time_reg;
        wr.kind    = key_kind_reg;
        wr.temp    = key_temp_reg;
        count_next = wr.en ? (count_reg + etd_pkg::cnt_t'(1)) : count_reg;
        slot_out   = (status == etd_pkg::STAT_STORED)
                     ? etd_pkg::slot_t'(result.empty_idx) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= {3'b000, slot_out, etd_pkg::count_t'(count_next), status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### src/etd_checker.sv
`default_nettype none
`include "event_table_dedup_insert_unit_macros.svh"

module etd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [71:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    logic               beat_out;
    logic               in_wait;
    logic               out_wait;
    logic               full_beat;
    logic               store_beat;
    logic               count_full;
    etd_pkg::status_t   st;
    etd_pkg::count_t    cnt;
    etd_pkg::slot_t     slt;

    assign beat_out   = m_tvalid;
    assign in_wait    = s_tvalid && !s_tready;
    assign out_wait   = m_tvalid && !m_tready;
    assign st         = etd_pkg::status_t'(m_tdata[1:0]);
    assign cnt        = m_tdata[7:2];
    assign slt        = m_tdata[12:8];
    assign full_beat  = beat_out && (st == etd_pkg::STAT_FULL);
    assign store_beat = beat_out && (st == etd_pkg::STAT_STORED);
    assign count_full = (cnt == etd_pkg::count_t'(etd_pkg::EVENT_SLOTS));

    // A waiting event beat keeps its payload
    `ETD_ASSERT_NXT(a_in_hold, in_wait, s_tvalid && $stable(s_tdata), "event beat changed")
    // A stalled result beat keeps its payload
    `ETD_ASSERT_NXT(a_out_hold, out_wait, m_tvalid && $stable(m_tdata), "result beat changed")
    // A full report only comes with a full count
    `ETD_ASSERT_IMP(a_full_count, full_beat, count_full, "full reported with spare slots")
    // A stored event leaves at least one event in the table
    `ETD_ASSERT_IMP(a_stored_count, store_beat, cnt != '0, "stored event with empty count")
    // Only a store names a slot
    `ETD_ASSERT_IMP(a_slot_zero, beat_out && !store_beat, slt == '0, "slot set on a rejection")

endmodule

bind event_table_dedup_insert_unit etd_checker u_etd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/event_table_dedup_insert_unit_tb.sv
module event_table_dedup_insert_unit_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SCAN_CYCLES = etd_pkg::EVENT_SLOTS + 2;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;

    // One node event, laid out as on s_tdata (addr in the lowest bits)
    typedef struct packed {
        etd_pkg::temp_t temp;
        etd_pkg::kind_t kind;
        etd_pkg::time_t stamp;
        etd_pkg::addr_t addr;
    } node_event_t;

    // One insert result, laid out as on m_tdata (status in the lowest bits)
    typedef struct packed {
        logic [2:0]       pad;
        etd_pkg::slot_t   slot;
        etd_pkg::count_t  count;
        etd_pkg::status_t status;
    } outcome_t;

    // Shadow event table: predicts each insert and checks the results
    class event_table_scoreboard;
        etd_pkg::addr_t tab_addr  [etd_pkg::EVENT_SLOTS];
        etd_pkg::time_t tab_stamp [etd_pkg::EVENT_SLOTS];
        etd_pkg::kind_t tab_kind  [etd_pkg::EVENT_SLOTS];
        etd_pkg::temp_t tab_temp  [etd_pkg::EVENT_SLOTS];
        int unsigned    held;
        etd_pkg::addr_t marker;
        outcome_t       due_outcomes[$];
        node_event_t    kept_events[$];
        int unsigned    mismatches;

        function new();
            foreach (tab_addr[i])
            begin
                tab_addr[i]  = etd_pkg::MARKER_RESET;
                tab_stamp[i] = '0;
                tab_kind[i]  = '0;
                tab_temp[i]  = '0;
            end
            held       = 0;
            marker     = etd_pkg::MARKER_RESET;
            mismatches = 0;
        endfunction

        // Walk the table as the block does and queue the outcome
        function void note_event(node_event_t ev);
            outcome_t    o;
            bit          dup;
            bit          have_empty;
            int unsigned empty_at;
            int unsigned seen;
            int unsigned i;
            o          = '0;
            dup        = 1'b0;
            have_empty = 1'b0;
            empty_at   = 0;
            seen       = 0;
            i          = 0;
            if (held >= etd_pkg::EVENT_SLOTS)
            begin
                o.status = etd_pkg::STAT_FULL;
            end
            else
            begin
                while (!dup && seen <= held && i < etd_pkg::EVENT_SLOTS)
                begin
                    if (tab_addr[i] == ev.addr)
                    begin
                        seen++;
                        if (tab_stamp[i] == ev.stamp && tab_kind[i] == ev.kind)
                            dup = 1'b1;
                    end
                    else if (tab_addr[i] == marker)
                    begin
                        // count only the first empty slot
                        if (!have_empty)
                        begin
                            have_empty = 1'b1;
                            empty_at   = i;
                            seen++;
                        end
                    end
                    else
                    begin
                        seen++;
                    end
                    i++;
                end
                if (dup)
                    o.status = etd_pkg::STAT_DUP;
                else if (!have_empty)
                    o.status = etd_pkg::STAT_NOSLOT;
                else
                begin
                    tab_addr[empty_at]  = ev.addr;
                    tab_stamp[empty_at] = ev.stamp;
                    tab_kind[empty_at]  = ev.kind;
                    tab_temp[empty_at]  = ev.temp;
                    held++;
                    o.status = etd_pkg::STAT_STORED;
                    o.slot   = etd_pkg::slot_t'(empty_at);
                    kept_events.push_back(ev);
                end
            end
            o.count = etd_pkg::count_t'(held);
            due_outcomes.push_back(o);
        endfunction

        // Compare a result beat with the oldest outstanding outcome
        function void check_outcome(outcome_t got);
            outcome_t want;
            if (due_outcomes.size() == 0)
            begin
                $error("insert result %h with no event outstanding", got);
                mismatches++;
                return;
            end
            want = due_outcomes.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("event_count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                mismatches++;
            end
            if (got.pad !== want.pad)
            begin
                $error("padding: expected %0d, got %0d", want.pad, got.pad);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;    // node_addr, event_time, event_kind, temperature
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // status, event_count, slot, zero padding
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    event_table_dedup_insert_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    event_table_scoreboard sb;
    bit                    calm = 1'b0;
    int unsigned           sink_left = 0;
    int unsigned           cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic node_event_t make_event(etd_pkg::addr_t a, etd_pkg::time_t s,
                                               etd_pkg::kind_t k, etd_pkg::temp_t t);
        node_event_t ev;
        ev.addr  = a;
        ev.stamp = s;
        ev.kind  = k;
        ev.temp  = t;
        return ev;
    endfunction

    // Mostly replays of stored events; a few new ones so the table fills slowly
    function automatic node_event_t random_event();
        node_event_t ev;
        node_event_t old;
        int unsigned r;
        int unsigned n;
        ev = make_event(16'($urandom), $urandom, 8'($urandom), 16'($urandom));
        n  = sb.kept_events.size();
        r  = $urandom_range(0, 99);
        if (n != 0)
            old = sb.kept_events[$urandom_range(0, n - 1)];
        if (r < 5)
        begin
            // near miss of a stored event, or leave it fresh
            if (n != 0 && r[0])
            begin
                ev.addr = old.addr;
                if ($urandom_range(0, 1))
                begin
                    ev.stamp = old.stamp;
                    ev.kind  = old.kind ^ etd_pkg::kind_t'(1 << $urandom_range(0, 7));
                end
                else
                begin
                    ev.kind  = old.kind;
                    ev.stamp = old.stamp ^ (32'd1 << $urandom_range(0, 31));
                end
            end
        end
        else if (r < 70 && n != 0)
        begin
            ev.addr  = old.addr;
            ev.stamp = old.stamp;
            ev.kind  = old.kind;
        end
        else if (r < 85)
        begin
            ev.addr = sb.marker;
            if (n != 0 && $urandom_range(0, 1))
            begin
                ev.stamp = old.stamp;
                ev.kind  = old.kind;
            end
        end
        else
        begin
            // look like a cleared slot
            ev.addr = etd_pkg::MARKER_RESET;
            if ($urandom_range(0, 1))
            begin
                ev.stamp = '0;
                ev.kind  = '0;
            end
        end
        return ev;
    endfunction

    // Offer one event and hold it until the block takes it
    task automatic send_event(input node_event_t ev);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ev;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.due_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // One register transfer; leaves psel high for a following transfer
    task automatic apb_access(input bit wr, input etd_pkg::addr_t val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {etd_pkg::REG_EMPTY_MARKER, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (wr)
            sb.marker = val;
        else if (prdata !== {16'h0000, sb.marker})
        begin
            $error("empty_marker: expected %h, got %h", sb.marker, prdata);
            sb.mismatches++;
        end
    endtask

    // Write the marker, read it back, release the bus
    task automatic set_marker(input etd_pkg::addr_t val);
        apb_access(1'b1, val);
        apb_access(1'b0, val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result sink: alternate ready stretches and stalls
    always @(posedge clk)
    begin
        if (sink_left != 0)
            sink_left <= sink_left - 1;
        else if (calm || $urandom_range(0, 2) != 0)
        begin
            m_tready  <= 1'b1;
            sink_left <= $urandom_range(0, 15);
        end
        else
        begin
            m_tready  <= 1'b0;
            sink_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4)
                                                      : $urandom_range(20, 80);
        end
    end

    // Monitor both streams; results first, as they belong to earlier events
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_outcome(outcome_t'(m_tdata));
            if (s_tvalid && s_tready)
                sb.note_event(node_event_t'(s_tdata));
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int unsigned    phase;
        int unsigned    tries;
        int unsigned    n;
        etd_pkg::addr_t mark;
        node_event_t    ev;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Check the reset value, then write it explicitly
        apb_access(1'b0, etd_pkg::MARKER_RESET);
        set_marker(etd_pkg::MARKER_RESET);

        // Directed: field extremes, duplicates, near misses, marker addresses
        send_event(make_event(16'h0000, 32'h0000_0000, 8'h00, 16'h8000));
        send_event(make_event(16'hFFFE, 32'hFFFF_FFFF, 8'hFF, 16'h7FFF));
        send_event(make_event(16'h0000, 32'h0000_0000, 8'h00, 16'hFFFF));
        send_event(make_event(16'hFFFE, 32'hFFFF_FFFF, 8'hFE, 16'h0000));
        send_event(make_event(16'hFFFE, 32'hFFFF_FFFE, 8'hFF, 16'h0000));
        send_event(make_event(etd_pkg::MARKER_RESET, 32'h0000_0000, 8'h00, 16'h0001));
        send_event(make_event(etd_pkg::MARKER_RESET, 32'h0000_0001, 8'h00, 16'h0001));
        send_event(make_event(16'h1234, 32'hA5A5_A5A5, 8'h5A, 16'h5A5A));
        drain();
        // Marker moved onto a stored address: that slot reads as empty
        set_marker(16'h0000);
        send_event(make_event(16'h0001, 32'h0000_0007, 8'h03, 16'h0100));
        send_event(make_event(16'h0000, 32'h0000_0000, 8'h00, 16'h0000));
        send_event(make_event(etd_pkg::MARKER_RESET, 32'h0000_0000, 8'h00, 16'h0000));
        drain();
        // Matching address wins over the marker
        set_marker(16'hFFFE);
        send_event(make_event(16'hFFFE, 32'hFFFF_FFFF, 8'hFF, 16'h0000));
        send_event(make_event(16'h4321, 32'h1234_5678, 8'h81, 16'hC000));

        // Random phases, each under a marker chosen for that phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            n = sb.kept_events.size();
            case (phase)
                1:       mark = '0;
                3, 6:    mark = (n != 0) ? sb.kept_events[$urandom_range(0, n - 1)].addr
                                         : etd_pkg::addr_t'($urandom);
                5:       mark = etd_pkg::addr_t'($urandom);
                default: mark = etd_pkg::MARKER_RESET;
            endcase
            set_marker(mark);
            calm = (phase == 2 || phase == 5);
            repeat (PHASE_ITEMS) send_event(random_event());
        end

        // Fill the table with fresh events, then keep knocking on it
        drain();
        calm = 1'b0;
        set_marker(etd_pkg::MARKER_RESET);
        tries = 0;
        while (sb.held < etd_pkg::EVENT_SLOTS && tries < 40)
        begin
            ev = make_event(etd_pkg::addr_t'($urandom_range(0, 16'hFFFE)), $urandom,
                            8'($urandom), 16'($urandom));
            send_event(ev);
            tries++;
        end
        repeat (24) send_event(random_event());

        drain();
        repeat (SCAN_CYCLES + 8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
